// File: hw/rtl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg
// Shared constants, codes and types of the polygon region lookup block.
// ----------------------------------------------------------------------------
package prl_pkg;

   localparam int NUM_REGIONS_DEF = 16;
   localparam int MAX_VERTS_DEF   = 256;
   localparam int COORD_BITS_DEF  = 16;

   localparam int ID_BITS    = 8;
   localparam int MODE_BITS  = 2;
   localparam int SLOT_BITS  = 4;
   localparam int VIDX_BITS  = 8;
   localparam int VCNT_BITS  = 9;

   localparam logic [MODE_BITS-1:0] MODE_VERTEX = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_HEADER = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_QUERY  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_SCHK,
      ST_VERT,
      ST_CLOSE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic               valid;
      logic               last;
      logic [ID_BITS-1:0] ident;
   } edge_tag_type;

   typedef struct packed {
      logic               valid;
      logic               last;
      logic               hit;
      logic [ID_BITS-1:0] ident;
   } edge_res_type;

endpackage

// File: hw/rtl/prl_vertex_mem.sv
// ----------------------------------------------------------------------------
// prl_vertex_mem
// Vertex store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prl_vertex_mem #(
   parameter int DEPTH      = 4096,
   parameter int AW         = 12,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic signed [COORD_BITS-1:0] wr_x,
   input  logic signed [COORD_BITS-1:0] wr_y,
   input  logic [AW-1:0]                rd_addr,
   output logic signed [COORD_BITS-1:0] rd_x,
   output logic signed [COORD_BITS-1:0] rd_y
);

   logic [2*COORD_BITS-1:0] mem [DEPTH];
   logic [2*COORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_x, wr_y};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_x = $signed(rd_data_ff[2*COORD_BITS-1:COORD_BITS]);
   assign rd_y = $signed(rd_data_ff[COORD_BITS-1:0]);

endmodule

// File: hw/rtl/prl_slot_table.sv
// ----------------------------------------------------------------------------
// prl_slot_table
// Per-slot region id and vertex count; a slot never written reads as empty.
// ----------------------------------------------------------------------------
module prl_slot_table #(
   parameter int NUM_REGIONS = 16,
   parameter int SB          = 4,
   parameter int CW          = 9
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [SB-1:0]               wr_slot,
   input  logic [prl_pkg::ID_BITS-1:0] wr_ident,
   input  logic [CW-1:0]               wr_size,
   input  logic [SB-1:0]               rd_slot,
   output logic [prl_pkg::ID_BITS-1:0] rd_ident,
   output logic [CW-1:0]               rd_size
);
   import prl_pkg::*;

   logic [ID_BITS+CW-1:0] mem [NUM_REGIONS];
   logic [NUM_REGIONS-1:0] valid_ff;
   logic [ID_BITS+CW-1:0] rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= {wr_ident, wr_size};
      end
      rd_data_ff  <= mem[rd_slot];
      rd_valid_ff <= valid_ff[rd_slot];
   end

   assign rd_ident = rd_data_ff[ID_BITS+CW-1:CW];
   assign rd_size  = rd_valid_ff ? rd_data_ff[CW-1:0] : '0;

endmodule

// File: hw/rtl/prl_edge_test.sv
// ----------------------------------------------------------------------------
// prl_edge_test
// Three-stage crossing test of one edge against the query point.
// ----------------------------------------------------------------------------
module prl_edge_test #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  prl_pkg::edge_tag_type        tag_i,
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by,
   input  logic signed [COORD_BITS-1:0] tx,
   input  logic signed [COORD_BITS-1:0] ty,
   output prl_pkg::edge_res_type        res_o,
   output logic                         busy_o
);
   import prl_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int W1 = C + 1;
   localparam int WN = C + 2;
   localparam int WT = 2 * C + 2;
   localparam int WP = 2 * C + 3;

   // stage 1
   logic signed [W1-1:0] ax_e, ay_e, bx_e, by_e, tx_e, ty_e;
   logic signed [W1-1:0] na, nb, dd, tt, dmag;
   logic signed [WN-1:0] nb_e, nbs;
   logic                 den_neg, y_in, x_in;
   logic signed [C-1:0]  xmax;

   edge_tag_type         tag1_ff;
   logic                 pre1_ff, vert1_ff;
   logic signed [W1-1:0] na1_ff, tt1_ff, d1_ff;
   logic signed [WN-1:0] nbs1_ff;

   // stage 2
   edge_tag_type         tag2_ff;
   logic                 pre2_ff, vert2_ff;
   logic signed [WP-1:0] p2_ff;
   logic signed [WT-1:0] td2_ff;
   logic signed [W1-1:0] d2_ff;

   // stage 3
   logic signed [WP-1:0] tdx, dx, tdm;
   logic                 cmp, hit;
   edge_res_type         res_ff;

   always_comb begin
      ax_e = {ax[C-1], ax};
      ay_e = {ay[C-1], ay};
      bx_e = {bx[C-1], bx};
      by_e = {by[C-1], by};
      tx_e = {tx[C-1], tx};
      ty_e = {ty[C-1], ty};
      na = ty_e - ay_e;
      nb = bx_e - ax_e;
      dd = by_e - ay_e;
      tt = tx_e - ax_e;
      den_neg = dd[W1-1];
      // fold the sign of the denominator into the numerator
      nb_e = {nb[W1-1], nb};
      nbs  = den_neg ? -nb_e : nb_e;
      dmag = den_neg ? -dd : dd;
      // half-open y span; a flat edge fails both arms
      y_in = (ay < by) ? (ty > ay && ty <= by) : (ty > by && ty <= ay);
      xmax = (ax < bx) ? bx : ax;
      x_in = (tx <= xmax);
   end

   always_comb begin
      tdx = {{(WP-WT){td2_ff[WT-1]}}, td2_ff};
      dx  = {{(WP-W1){d2_ff[W1-1]}}, d2_ff};
      tdm = tdx - dx;
      // t <= trunc(p/d): floor for p >= 0, ceiling for p < 0
      cmp = p2_ff[WP-1] ? (tdm < p2_ff) : (tdx <= p2_ff);
      hit = pre2_ff && (vert2_ff || cmp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         res_ff.valid  <= 1'b0;
      end else begin
         tag1_ff.valid <= tag_i.valid;
         tag2_ff.valid <= tag1_ff.valid;
         res_ff.valid  <= tag2_ff.valid;
      end

      tag1_ff.last  <= tag_i.last;
      tag1_ff.ident <= tag_i.ident;
      pre1_ff       <= y_in && x_in;
      vert1_ff      <= (ax == bx);
      na1_ff        <= na;
      nbs1_ff       <= nbs;
      tt1_ff        <= tt;
      d1_ff         <= dmag;

      tag2_ff.last  <= tag1_ff.last;
      tag2_ff.ident <= tag1_ff.ident;
      pre2_ff       <= pre1_ff;
      vert2_ff      <= vert1_ff;
      p2_ff         <= na1_ff * nbs1_ff;
      td2_ff        <= tt1_ff * d1_ff;
      d2_ff         <= d1_ff;

      res_ff.last   <= tag2_ff.last;
      res_ff.ident  <= tag2_ff.ident;
      res_ff.hit    <= hit;
   end

   assign res_o  = res_ff;
   assign busy_o = tag1_ff.valid || tag2_ff.valid || res_ff.valid;

endmodule

// File: hw/rtl/polygon_region_lookup.sv
// ----------------------------------------------------------------------------
// polygon_region_lookup
// Point-in-polygon region lookup over a store of polygon slots.
// ----------------------------------------------------------------------------
// Vertex and header writes each return a registered word. A query reads the
// vertex memory through its read port one vertex per cycle, slot by slot,
// skipping empty slots, and at the end of the query drains the three-stage
// edge pipeline before its word is returned. There is no clearing pass after
// reset; slot counts come up zero at once.
module polygon_region_lookup #(
   parameter int NUM_REGIONS = prl_pkg::NUM_REGIONS_DEF,
   parameter int MAX_VERTS   = prl_pkg::MAX_VERTS_DEF,
   parameter int COORD_BITS  = prl_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [prl_pkg::MODE_BITS-1:0] req_mode,
   input  logic [prl_pkg::SLOT_BITS-1:0] req_slot,
   input  logic [prl_pkg::VIDX_BITS-1:0] req_vertex_index,
   input  logic signed [COORD_BITS-1:0]  req_coord_x,
   input  logic signed [COORD_BITS-1:0]  req_coord_y,
   input  logic [prl_pkg::ID_BITS-1:0]   req_region_ident,
   input  logic [prl_pkg::VCNT_BITS-1:0] req_vertex_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [prl_pkg::ID_BITS-1:0]   rsp_region_code,
   input  logic                          csr_wr_en,
   input  logic [prl_pkg::ID_BITS-1:0]   csr_wr_data
);
   import prl_pkg::*;

   localparam int SB    = $clog2(NUM_REGIONS);
   localparam int VIB   = $clog2(MAX_VERTS);
   localparam int CW    = $clog2(MAX_VERTS + 1);
   localparam int DEPTH = NUM_REGIONS * MAX_VERTS;
   localparam int AW    = $clog2(DEPTH);

   state_type state_ff, state_in;

   logic [ID_BITS-1:0]          no_region_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [ID_BITS-1:0]          rsp_code_ff, rsp_code_in;
   logic signed [COORD_BITS-1:0] pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic [SB-1:0]               slot_ff, slot_in;
   logic [AW-1:0]               base_ff, base_in;
   logic [VIB-1:0]              cnt_ff, cnt_in;
   logic [CW-1:0]               size_ff, size_in;
   logic [ID_BITS-1:0]          ident_ff, ident_in;
   logic signed [COORD_BITS-1:0] v0x_ff, v0x_in, v0y_ff, v0y_in;
   logic signed [COORD_BITS-1:0] prevx_ff, prevx_in, prevy_ff, prevy_in;
   logic                        parity_ff, parity_in;
   logic                        hit_ff, hit_in;
   logic [ID_BITS-1:0]          best_ff, best_in;

   logic        accept, out_free, last_slot, cnt_last;
   logic [31:0] slot_ext, vi_ext, vc_ext, wr_addr_w, rd_addr_w, size_sat;
   logic        slot_ok, vi_ok, vtx_we, hdr_we, par;

   logic [AW-1:0]                mem_rd_addr;
   logic signed [COORD_BITS-1:0] mem_x, mem_y;
   logic [ID_BITS-1:0]           tbl_ident;
   logic [CW-1:0]                tbl_size;

   edge_tag_type                 edge_tag;
   edge_res_type                 edge_res;
   logic signed [COORD_BITS-1:0] edge_bx, edge_by;
   logic                         edge_busy;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;

   // write decode
   always_comb begin
      slot_ext  = {{(32-SLOT_BITS){1'b0}}, req_slot};
      vi_ext    = {{(32-VIDX_BITS){1'b0}}, req_vertex_index};
      vc_ext    = {{(32-VCNT_BITS){1'b0}}, req_vertex_count};
      slot_ok   = slot_ext < 32'(NUM_REGIONS);
      vi_ok     = vi_ext < 32'(MAX_VERTS);
      wr_addr_w = slot_ext * 32'(MAX_VERTS) + vi_ext;
      size_sat  = (vc_ext > 32'(MAX_VERTS)) ? 32'(MAX_VERTS) : vc_ext;
      vtx_we    = accept && (req_mode == MODE_VERTEX) && slot_ok && vi_ok;
      hdr_we    = accept && (req_mode == MODE_HEADER) && slot_ok;
   end

   always_comb begin
      last_slot = (slot_ff == SB'(NUM_REGIONS - 1));
      cnt_last  = (CW'(cnt_ff) == size_ff - CW'(1));
      rd_addr_w = (state_ff == ST_VERT) ?
                  32'(base_ff) + 32'(cnt_ff) + 32'd1 : 32'(base_ff);
      mem_rd_addr = rd_addr_w[AW-1:0];
   end

   prl_vertex_mem #(
      .DEPTH      (DEPTH),
      .AW         (AW),
      .COORD_BITS (COORD_BITS)
   ) u_vertex_mem (
      .clock   (clock),
      .wr_en   (vtx_we),
      .wr_addr (wr_addr_w[AW-1:0]),
      .wr_x    (req_coord_x),
      .wr_y    (req_coord_y),
      .rd_addr (mem_rd_addr),
      .rd_x    (mem_x),
      .rd_y    (mem_y)
   );

   prl_slot_table #(
      .NUM_REGIONS (NUM_REGIONS),
      .SB          (SB),
      .CW          (CW)
   ) u_slot_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (hdr_we),
      .wr_slot  (slot_ext[SB-1:0]),
      .wr_ident (req_region_ident),
      .wr_size  (size_sat[CW-1:0]),
      .rd_slot  (slot_ff),
      .rd_ident (tbl_ident),
      .rd_size  (tbl_size)
   );

   assign edge_bx = (state_ff == ST_CLOSE) ? v0x_ff : mem_x;
   assign edge_by = (state_ff == ST_CLOSE) ? v0y_ff : mem_y;

   always_comb begin
      edge_tag.valid = ((state_ff == ST_VERT) && (cnt_ff != '0)) ||
                       (state_ff == ST_CLOSE);
      edge_tag.last  = (state_ff == ST_CLOSE);
      edge_tag.ident = ident_ff;
   end

   prl_edge_test #(
      .COORD_BITS (COORD_BITS)
   ) u_edge_test (
      .clock  (clock),
      .reset  (reset),
      .tag_i  (edge_tag),
      .ax     (prevx_ff),
      .ay     (prevy_ff),
      .bx     (edge_bx),
      .by     (edge_by),
      .tx     (pt_x_ff),
      .ty     (pt_y_ff),
      .res_o  (edge_res),
      .busy_o (edge_busy)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_QUERY)) state_in = ST_SLOT;
         end
         ST_SLOT: begin
            state_in = ST_SCHK;
         end
         ST_SCHK: begin
            if (tbl_size != '0) state_in = ST_VERT;
            else if (last_slot) state_in = ST_DRAIN;
            else state_in = ST_SLOT;
         end
         ST_VERT: begin
            if (cnt_last) state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            state_in = last_slot ? ST_DRAIN : ST_SLOT;
         end
         ST_DRAIN: begin
            if (!edge_busy && out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_code_in  = rsp_code_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      slot_in      = slot_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      size_in      = size_ff;
      ident_in     = ident_ff;
      v0x_in       = v0x_ff;
      v0y_in       = v0y_ff;
      prevx_in     = prevx_ff;
      prevy_in     = prevy_ff;
      parity_in    = parity_ff;
      hit_in       = hit_ff;
      best_in      = best_ff;
      par          = parity_ff ^ edge_res.hit;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_QUERY) begin
                  pt_x_in   = req_coord_x;
                  pt_y_in   = req_coord_y;
                  slot_in   = '0;
                  base_in   = '0;
                  parity_in = 1'b0;
                  hit_in    = 1'b0;
                  best_in   = '0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_code_in  = no_region_ff;
               end
            end
         end
         ST_SCHK: begin
            size_in  = tbl_size;
            ident_in = tbl_ident;
            cnt_in   = '0;
            if (tbl_size == '0) begin
               slot_in = slot_ff + SB'(1);
               base_in = base_ff + AW'(MAX_VERTS);
            end
         end
         ST_VERT: begin
            if (cnt_ff == '0) begin
               v0x_in = mem_x;
               v0y_in = mem_y;
            end
            prevx_in = mem_x;
            prevy_in = mem_y;
            if (!cnt_last) cnt_in = cnt_ff + VIB'(1);
         end
         ST_CLOSE: begin
            slot_in = slot_ff + SB'(1);
            base_in = base_ff + AW'(MAX_VERTS);
         end
         ST_DRAIN: begin
            if (!edge_busy && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_code_in  = hit_ff ? best_ff : no_region_ff;
            end
         end
         default: begin
         end
      endcase

      // odd crossing count on the slot's closing edge means inside
      if (edge_res.valid) begin
         if (edge_res.last) begin
            parity_in = 1'b0;
            if (par) begin
               hit_in = 1'b1;
               if (!hit_ff || (edge_res.ident < best_ff)) best_in = edge_res.ident;
            end
         end else begin
            parity_in = par;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         no_region_ff <= '1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) no_region_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_code_ff  <= rsp_code_in;
      pt_x_ff      <= pt_x_in;
      pt_y_ff      <= pt_y_in;
      slot_ff      <= slot_in;
      base_ff      <= base_in;
      cnt_ff       <= cnt_in;
      size_ff      <= size_in;
      ident_ff     <= ident_in;
      v0x_ff       <= v0x_in;
      v0y_ff       <= v0y_in;
      prevx_ff     <= prevx_in;
      prevy_ff     <= prevy_in;
      parity_ff    <= parity_in;
      hit_ff       <= hit_in;
      best_ff      <= best_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_region_code = rsp_code_ff;

   a_no_edge_in_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !edge_res.valid)
      else $error("edge result outside a query");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_QUERY) |=> state_ff == ST_SLOT)
      else $error("query did not start slot scan");

   a_close_after_vert: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLOSE |-> $past(state_ff) == ST_VERT)
      else $error("closing edge without vertex walk");

   a_miss_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> rsp_region_code == no_region_ff)
      else $error("miss word without no-region code");

endmodule

// File: verif/polygon_region_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_region_lookup_tb
// Loads polygons into the slot store and sends point queries with random
// gaps on both channels. Every word is checked against a crossing-number
// predictor kept in the scoreboard, across several no-region codes.
// ----------------------------------------------------------------------------
module polygon_region_lookup_tb;
   import prl_pkg::*;

   localparam int NSLOT = NUM_REGIONS_DEF;
   localparam int NVERT = MAX_VERTS_DEF;
   localparam int CBITS = COORD_BITS_DEF;
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [SLOT_BITS-1:0] slot;
      logic [VIDX_BITS-1:0] vidx;
      logic signed [CBITS-1:0] x;
      logic signed [CBITS-1:0] y;
      logic [ID_BITS-1:0] rid;
      logic [VCNT_BITS-1:0] vcnt;
   } req_word_t;

   typedef struct packed {
      logic found;
      logic [ID_BITS-1:0] code;
   } rsp_word_t;

   class region_scoreboard;
      logic [ID_BITS-1:0] miss_code = 8'd255;
      longint vx [NSLOT*NVERT];
      longint vy [NSLOT*NVERT];
      logic [ID_BITS-1:0] ids [NSLOT];
      int sizes [NSLOT];
      rsp_word_t expected_q[$];
      int errors = 0;

      function new();
         foreach (sizes[i]) begin
            sizes[i] = 0;
            ids[i] = '0;
         end
      endfunction

      function void set_miss_code(logic [ID_BITS-1:0] v);
         miss_code = v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit edge_crosses(longint ax, longint ay, longint bx, longint by,
                                longint tx, longint ty);
         longint lo, hi, xmax, q;
         lo = (ay < by) ? ay : by;
         hi = (ay < by) ? by : ay;
         xmax = (ax < bx) ? bx : ax;
         if (!(ty > lo && ty <= hi)) return 0;
         if (tx > xmax) return 0;
         if (ay == by) return 0;
         if (ax == bx) return 1;
         // signed longint division truncates toward zero
         q = ((ty - ay) * (bx - ax)) / (by - ay);
         return tx <= q + ax;
      endfunction

      function bit slot_holds(int s, longint tx, longint ty);
         int n, b, j;
         bit odd;
         n = sizes[s];
         b = s * NVERT;
         odd = 0;
         for (int i = 0; i < n; i++) begin
            j = (i + 1 < n) ? i + 1 : 0;
            if (edge_crosses(vx[b+i], vy[b+i], vx[b+j], vy[b+j], tx, ty)) odd = !odd;
         end
         return odd;
      endfunction

      function void note_input(req_word_t r);
         rsp_word_t e;
         int n;
         e.found = 0;
         e.code = miss_code;
         case (r.mode)
            MODE_VERTEX: begin
               vx[r.slot*NVERT + r.vidx] = longint'(r.x);
               vy[r.slot*NVERT + r.vidx] = longint'(r.y);
            end
            MODE_HEADER: begin
               n = int'(r.vcnt);
               ids[r.slot] = r.rid;
               sizes[r.slot] = (n > NVERT) ? NVERT : n;
            end
            MODE_QUERY: begin
               for (int k = 0; k < NSLOT; k++) begin
                  if (sizes[k] != 0 && slot_holds(k, longint'(r.x), longint'(r.y))) begin
                     if (!e.found || ids[k] < e.code) e.code = ids[k];
                     e.found = 1;
                  end
               end
            end
            default: ;
         endcase
         expected_q = {expected_q, e};
      endfunction

      function void check_result(rsp_word_t got);
         rsp_word_t e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word found=%0d code=%0d",
                                       got.found, got.code);
            return;
         end
         e = expected_q.pop_front();
         if (got.found !== e.found || got.code !== e.code) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected found=%0d code=%0d, got found=%0d code=%0d",
                        e.found, e.code, got.found, got.code);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   req_word_t req_w;
   logic rsp_valid, rsp_ready, rsp_found;
   logic [ID_BITS-1:0] rsp_region_code;
   logic csr_wr_en;
   logic [ID_BITS-1:0] csr_wr_data;

   region_scoreboard sb = new();
   bit vtx_written [NSLOT][NVERT];
   bit quiet = 0;
   int stall_cycles = 0;

   polygon_region_lookup u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_w.mode),
      .req_slot         (req_w.slot),
      .req_vertex_index (req_w.vidx),
      .req_coord_x      (req_w.x),
      .req_coord_y      (req_w.y),
      .req_region_ident (req_w.rid),
      .req_vertex_count (req_w.vcnt),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_region_code  (rsp_region_code),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_input(req_w);
         if (rsp_valid && rsp_ready) sb.check_result({rsp_found, rsp_region_code});
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("polygon_region_lookup_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic send(input req_word_t r);
      if (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < 50) @(posedge clock);
      end
      req_valid <= 1;
      req_w <= r;
      if (r.mode == MODE_VERTEX) vtx_written[r.slot][r.vidx] = 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ID_BITS-1:0] v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.set_miss_code(v);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   function automatic req_word_t noise_word(logic [MODE_BITS-1:0] m);
      req_word_t r;
      r = $bits(req_word_t)'({$urandom, $urandom});
      r.mode = m;
      return r;
   endfunction

   task automatic put_vertex(int s, int i, int x, int y);
      req_word_t r;
      r = noise_word(MODE_VERTEX);
      r.slot = SLOT_BITS'(s); r.vidx = VIDX_BITS'(i); r.x = CBITS'(x); r.y = CBITS'(y);
      send(r);
   endtask

   task automatic put_header(int s, int id, int n);
      req_word_t r;
      r = noise_word(MODE_HEADER);
      r.slot = SLOT_BITS'(s); r.rid = ID_BITS'(id); r.vcnt = VCNT_BITS'(n);
      send(r);
   endtask

   task automatic ask(int x, int y);
      req_word_t r;
      r = noise_word(MODE_QUERY);
      r.x = CBITS'(x); r.y = CBITS'(y);
      send(r);
   endtask

   function automatic int written_prefix(int s);
      int p;
      p = 0;
      while (p < NVERT && vtx_written[s][p]) p++;
      return p;
   endfunction

   function automatic int rand_coord(bit full);
      if (full) return int'($signed(16'($urandom)));
      return int'($urandom_range(0, 160)) - 80;
   endfunction

   task automatic random_word();
      int pick, s, n, p;
      bit full;
      pick = $urandom_range(99);
      if (pick < 40) begin
         // well-formed polygon: vertices first, then its header
         s = $urandom_range(NSLOT-1);
         n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
         full = ($urandom_range(3) == 0);
         for (int i = 0; i < n; i++) put_vertex(s, i, rand_coord(full), rand_coord(full));
         put_header(s, ($urandom_range(1) ? $urandom_range(15) : $urandom_range(255)), n);
      end else if (pick < 85) begin
         full = ($urandom_range(4) == 0);
         ask(rand_coord(full), rand_coord(full));
      end else if (pick < 92) begin
         send(noise_word(MODE_UNUSED));
      end else begin
         s = $urandom_range(NSLOT-1);
         p = written_prefix(s);
         n = ($urandom_range(1) || p == 0) ? 0 : $urandom_range(1, (p > 8) ? 8 : p);
         put_header(s, $urandom_range(255), n);
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_w = '0;
      csr_wr_en = 0;
      csr_wr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: square, extreme triangle, tiny polygon, oversized count
      write_csr(8'd0);
      put_vertex(0, 0, -100, -100);
      put_vertex(0, 1, 100, -100);
      put_vertex(0, 2, 100, 100);
      put_vertex(0, 3, -100, 100);
      put_header(0, 7, 4);
      put_vertex(1, 0, -32768, -32768);
      put_vertex(1, 1, 32767, -32768);
      put_vertex(1, 2, 0, 32767);
      put_header(1, 3, 3);
      ask(0, 0);
      ask(150, 0);
      ask(32767, 32767);
      ask(-32768, -32768);
      ask(-100, 100);
      send(noise_word(MODE_UNUSED));
      put_vertex(2, 0, 5, 5);
      put_header(2, 0, 1);
      ask(5, 5);
      put_vertex(3, 255, 32767, -32768);
      put_header(3, 255, 511);
      put_header(3, 255, 0);
      put_header(1, 7, 3);
      ask(0, 0);
      drain();

      write_csr(8'd255);
      for (int k = 0; k < 40; k++) begin
         quiet = (k >= 16 && k < 28);
         if (k == 12) begin
            drain();
            write_csr(8'($urandom));
         end
         if (k == 26) begin
            drain();
            write_csr(8'd128);
         end
         random_word();
      end
      quiet = 0;
      drain();

      if (sb.errors == 0) $display("polygon_region_lookup_tb: PASS");
      else $display("polygon_region_lookup_tb: FAIL");
      $finish;
   end

endmodule
